[hw/rtl/headset_jack_detect_debounce_top_assert.svh]
// Assertion macros for the headset jack detect and button debounce block.
`ifndef HEADSET_JACK_DETECT_DEBOUNCE_TOP_ASSERT_SVH
`define HEADSET_JACK_DETECT_DEBOUNCE_TOP_ASSERT_SVH

// Same-cycle implication, checked on the rising edge of i_clk outside reset.
`define HJDD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising edge of i_clk outside reset.
`define HJDD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/hjdd_pkg.sv]
// Shared types and constants of the headset jack detect and button debounce block.
`default_nettype none

package hjdd_pkg;

    // Configuration port geometry
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Register values after reset
    localparam logic [CFG_W-1:0] PLUG_TICKS_RST    = 16'd250;
    localparam logic [CFG_W-1:0] UNPLUG_TICKS_RST  = 16'd10;
    localparam logic [CFG_W-1:0] PRESS_TICKS_RST   = 16'd30;
    localparam logic [CFG_W-1:0] RELEASE_TICKS_RST = 16'd40;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLUG    = 2'd0,
        CFG_UNPLUG  = 2'd1,
        CFG_PRESS   = 2'd2,
        CFG_RELEASE = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        JACK_EMPTY  = 2'd0,
        JACK_MIC    = 2'd1,
        JACK_PHONES = 2'd2
    } t_jack;

    typedef enum logic [1:0] {
        JEV_NONE    = 2'd0,
        JEV_MIC     = 2'd1,
        JEV_PHONES  = 2'd2,
        JEV_REMOVED = 2'd3
    } t_jack_ev;

    typedef enum logic [1:0] {
        BEV_NONE    = 2'd0,
        BEV_PRESS   = 2'd1,
        BEV_RELEASE = 2'd2
    } t_btn_ev;

    typedef struct packed {
        logic [CFG_W-1:0] plug_ticks;
        logic [CFG_W-1:0] unplug_ticks;
        logic [CFG_W-1:0] press_ticks;
        logic [CFG_W-1:0] rel_ticks;
    } t_cfg;

    // Timer control for one tick: cancel wins over load
    typedef struct packed {
        logic             load;
        logic             cancel;
        logic [CFG_W-1:0] value;
    } t_timer_ctl;

    typedef struct packed {
        t_jack    jack_state;
        logic     button_down;
        t_jack_ev jack_event;
        t_btn_ev  button_event;
    } t_result;

endpackage

`default_nettype wire

[hw/rtl/hjdd_in_if.sv]
// Input channel: one tick word with the sampled detect and button pin levels.
`default_nettype none

interface hjdd_in_if;
    logic valid;
    logic ready;
    logic detect_level;
    logic button_level;

    modport source (output valid, output detect_level, output button_level, input ready);
    modport sink   (input valid, input detect_level, input button_level, output ready);
endinterface

`default_nettype wire

[hw/rtl/hjdd_out_if.sv]
// Output channel: one result word per tick with jack and button state and events.
`default_nettype none

interface hjdd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] jack_state;
    logic       button_down;
    logic [1:0] jack_event;
    logic [1:0] button_event;

    modport source (output valid, output jack_state, output button_down,
                    output jack_event, output button_event, input ready);
    modport sink   (input valid, input jack_state, input button_down,
                    input jack_event, input button_event, output ready);
endinterface

`default_nettype wire

[hw/rtl/hjdd_timer.sv]
// Debounce timer: load or cancel, then fire on zero or count down, once per tick.
`default_nettype none

module hjdd_timer #(
    parameter int   TIMER_BITS = 16,
    parameter logic ACTIVE_RST = 1'b0
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_adv,
    input  wire hjdd_pkg::t_timer_ctl i_ctl,
    output      logic                 o_fire
);

    logic                  r_active;
    logic [TIMER_BITS-1:0] r_count;
    logic                  n_active;
    logic [TIMER_BITS-1:0] n_count;
    logic [TIMER_BITS-1:0] w_load;
    logic                  w_act_ld;
    logic [TIMER_BITS-1:0] w_cnt_ld;
    logic                  w_nonzero;

    // Fit the register value to the counter, saturating when the counter is short
    generate
        if (TIMER_BITS > hjdd_pkg::CFG_W) begin : g_wide
            assign w_load = {{(TIMER_BITS - hjdd_pkg::CFG_W){1'b0}}, i_ctl.value};
        end else if (TIMER_BITS == hjdd_pkg::CFG_W) begin : g_same
            assign w_load = i_ctl.value;
        end else begin : g_short
            assign w_load = (|i_ctl.value[hjdd_pkg::CFG_W-1:TIMER_BITS]) ?
                            {TIMER_BITS{1'b1}} : i_ctl.value[TIMER_BITS-1:0];
        end
    endgenerate

    // Apply cancel or load ahead of this tick's countdown
    always_comb begin
        if (i_ctl.cancel) begin
            w_act_ld = 1'b0;
            w_cnt_ld = '0;
        end else if (i_ctl.load) begin
            w_act_ld = 1'b1;
            w_cnt_ld = w_load;
        end else begin
            w_act_ld = r_active;
            w_cnt_ld = r_count;
        end
    end

    // Fire on zero, otherwise count down
    assign w_nonzero = (w_cnt_ld != '0);
    assign o_fire    = w_act_ld && !w_nonzero;
    assign n_active  = w_act_ld && w_nonzero;
    assign n_count   = (w_act_ld && w_nonzero) ? (w_cnt_ld - TIMER_BITS'(1)) : w_cnt_ld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_RST;
            r_count  <= '0;
        end else if (i_adv) begin
            r_active <= n_active;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/hjdd_core.sv]
// Jack classification and button reporting for one tick, with the two debounce timers.
`default_nettype none

module hjdd_core #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_adv,
    input  wire logic              i_det,
    input  wire logic              i_btn,
    input  wire hjdd_pkg::t_cfg    i_cfg,
    output      hjdd_pkg::t_result o_res
);

    hjdd_pkg::t_jack      r_jack;
    logic                 r_held;
    logic                 r_mic;
    logic                 r_prev_det;
    logic                 r_prev_btn;
    hjdd_pkg::t_jack      n_jack;
    logic                 n_held;
    logic                 n_mic;
    hjdd_pkg::t_jack_ev   w_jev;
    hjdd_pkg::t_btn_ev    w_bev;
    logic                 w_det_chg;
    logic                 w_btn_chg;
    logic                 w_det_fire;
    logic                 w_btn_fire;
    hjdd_pkg::t_timer_ctl w_det_ctl;
    hjdd_pkg::t_timer_ctl w_btn_ctl;

    assign w_det_chg = (i_det != r_prev_det);
    assign w_btn_chg = (i_btn != r_prev_btn);

    // Restart the detect timer on any detect edge; length depends on occupancy
    assign w_det_ctl.load   = w_det_chg;
    assign w_det_ctl.cancel = 1'b0;
    assign w_det_ctl.value  = (r_jack == hjdd_pkg::JACK_EMPTY) ? i_cfg.plug_ticks
                                                               : i_cfg.unplug_ticks;

    // Restart the button timer on a button edge with mic; drop it on a detect edge while occupied
    assign w_btn_ctl.load   = w_btn_chg && r_mic;
    assign w_btn_ctl.cancel = w_det_chg && (r_jack != hjdd_pkg::JACK_EMPTY);
    assign w_btn_ctl.value  = i_btn ? i_cfg.rel_ticks : i_cfg.press_ticks;

    hjdd_timer #(
        .TIMER_BITS (TIMER_BITS),
        .ACTIVE_RST (1'b1)
    ) u_det_timer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (i_adv),
        .i_ctl   (w_det_ctl),
        .o_fire  (w_det_fire)
    );

    hjdd_timer #(
        .TIMER_BITS (TIMER_BITS),
        .ACTIVE_RST (1'b0)
    ) u_btn_timer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (i_adv),
        .i_ctl   (w_btn_ctl),
        .o_fire  (w_btn_fire)
    );

    // Resolve detect expiry first, then button expiry against the updated jack state
    always_comb begin
        n_jack = r_jack;
        n_mic  = r_mic;
        n_held = r_held;
        w_jev  = hjdd_pkg::JEV_NONE;
        w_bev  = hjdd_pkg::BEV_NONE;
        if (w_det_fire) begin
            if (i_det) begin
                if (r_jack != hjdd_pkg::JACK_EMPTY) begin
                    n_jack = hjdd_pkg::JACK_EMPTY;
                    n_mic  = 1'b0;
                    w_jev  = hjdd_pkg::JEV_REMOVED;
                    if (r_held) begin
                        n_held = 1'b0;
                        w_bev  = hjdd_pkg::BEV_RELEASE;
                    end
                end
            end else if (r_jack == hjdd_pkg::JACK_EMPTY) begin
                if (i_btn) begin
                    n_jack = hjdd_pkg::JACK_MIC;
                    n_mic  = 1'b1;
                    w_jev  = hjdd_pkg::JEV_MIC;
                end else begin
                    n_jack = hjdd_pkg::JACK_PHONES;
                    w_jev  = hjdd_pkg::JEV_PHONES;
                end
            end
        end
        if (w_btn_fire && (n_jack == hjdd_pkg::JACK_MIC) && !i_det) begin
            if (!i_btn && !n_held) begin
                n_held = 1'b1;
                w_bev  = hjdd_pkg::BEV_PRESS;
            end else if (i_btn && n_held) begin
                n_held = 1'b0;
                w_bev  = hjdd_pkg::BEV_RELEASE;
            end
        end
    end

    assign o_res.jack_state   = n_jack;
    assign o_res.button_down  = n_held;
    assign o_res.jack_event   = w_jev;
    assign o_res.button_event = w_bev;

    // Commit the tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jack     <= hjdd_pkg::JACK_EMPTY;
            r_held     <= 1'b0;
            r_mic      <= 1'b0;
            r_prev_det <= 1'b1;
            r_prev_btn <= 1'b1;
        end else if (i_adv) begin
            r_jack     <= n_jack;
            r_held     <= n_held;
            r_mic      <= n_mic;
            r_prev_det <= i_det;
            r_prev_btn <= i_btn;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/headset_jack_detect_debounce_top.sv]
// Top level of the headset jack detect and button debounce block.
//
// Usage: each word on i_in is one tick carrying the sampled jack-detect and
// button pin levels (both active low). Every accepted word yields exactly one
// word on o_out with the jack state, the held-button flag and any jack or
// button event of that tick. Debounce lengths are set through the write port
// (i_cfg_we, i_cfg_idx, i_cfg_data): plug, unplug, press, release, in ticks.
// Write them only while no word is in flight.
// A word accepted into the input register is processed into the output register
// once o_out is free, so a stall on o_out can come between the two. Throughput
// is one word per cycle while o_out does not stall: the input register, one
// pass of compare and counter logic and the output register set the rate.
// Reset (i_rst_n low, synchronous) loads the default debounce lengths, empties
// the jack and arms a detection check that fires on the first tick.
// When o_out stalls, the output register holds its word and the input
// register takes one more word; i_in.ready drops only when both are full.
`default_nettype none

`include "headset_jack_detect_debounce_top_assert.svh"

module headset_jack_detect_debounce_top #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    hjdd_in_if.sink                             i_in,
    hjdd_out_if.source                          o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [hjdd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [hjdd_pkg::CFG_W-1:0]     i_cfg_data
);

    hjdd_pkg::t_cfg    r_cfg;
    logic              r_in_valid;
    logic              r_in_det;
    logic              r_in_btn;
    logic              r_out_valid;
    hjdd_pkg::t_result r_out;
    hjdd_pkg::t_result w_res;
    logic              w_adv;
    logic              w_in_take;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.plug_ticks   <= hjdd_pkg::PLUG_TICKS_RST;
            r_cfg.unplug_ticks <= hjdd_pkg::UNPLUG_TICKS_RST;
            r_cfg.press_ticks  <= hjdd_pkg::PRESS_TICKS_RST;
            r_cfg.rel_ticks    <= hjdd_pkg::RELEASE_TICKS_RST;
        end else if (i_cfg_we) begin
            unique case (hjdd_pkg::t_cfg_idx'(i_cfg_idx))
                hjdd_pkg::CFG_PLUG:    r_cfg.plug_ticks   <= i_cfg_data;
                hjdd_pkg::CFG_UNPLUG:  r_cfg.unplug_ticks <= i_cfg_data;
                hjdd_pkg::CFG_PRESS:   r_cfg.press_ticks  <= i_cfg_data;
                hjdd_pkg::CFG_RELEASE: r_cfg.rel_ticks    <= i_cfg_data;
                default:               r_cfg              <= r_cfg;
            endcase
        end
    end

    // Advance the held word when the output register is free or being drained
    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;
    assign w_in_take  = i_in.valid && i_in.ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_det <= i_in.detect_level;
            r_in_btn <= i_in.button_level;
        end
    end

    hjdd_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_det   (r_in_det),
        .i_btn   (r_in_btn),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.jack_state   = r_out.jack_state;
    assign o_out.button_down  = r_out.button_down;
    assign o_out.jack_event   = r_out.jack_event;
    assign o_out.button_event = r_out.button_event;

    // Checks on the word flow and on result consistency
    `HJDD_ASSERT_NEXT(a_adv_fills_out, w_adv, r_out_valid,
        "processed word not in output register")
    `HJDD_ASSERT_NEXT(a_stall_keeps_in, r_in_valid && r_out_valid && !o_out.ready,
        r_in_valid && $stable(r_in_det) && $stable(r_in_btn),
        "held input word lost during stall")
    `HJDD_ASSERT_IMPL(a_btn_needs_mic, o_out.valid && o_out.button_down,
        o_out.jack_state == hjdd_pkg::JACK_MIC,
        "button held without mic headset")
    `HJDD_ASSERT_IMPL(a_removed_is_empty,
        o_out.valid && (o_out.jack_event == hjdd_pkg::JEV_REMOVED),
        o_out.jack_state == hjdd_pkg::JACK_EMPTY,
        "removal event with jack occupied")

endmodule

`default_nettype wire

[tb/hjdd_tb_pkg.sv]
// Scoreboard class that predicts and checks the jack detect and button debounce results.
`timescale 1ns / 100ps

package hjdd_tb_pkg;

    import hjdd_pkg::*;

    // Timer slots of the predictor
    localparam int DET_TMR = 0;
    localparam int BTN_TMR = 1;

    class jack_scoreboard;

        logic [CFG_W-1:0] debounce [4];
        t_jack            jack;
        logic             held;
        logic             mic_in;
        logic             armed [2];
        logic [CFG_W-1:0] count [2];
        logic             prev_det;
        logic             prev_btn;
        t_result          pending_words [$];
        int               faults;
        int               reported;

        function new();
            faults   = 0;
            reported = 0;
            restore();
        endfunction

        // Load the state the block holds after reset
        function void restore();
            debounce[CFG_PLUG]    = PLUG_TICKS_RST;
            debounce[CFG_UNPLUG]  = UNPLUG_TICKS_RST;
            debounce[CFG_PRESS]   = PRESS_TICKS_RST;
            debounce[CFG_RELEASE] = RELEASE_TICKS_RST;
            jack           = JACK_EMPTY;
            held           = 1'b0;
            mic_in         = 1'b0;
            armed[DET_TMR] = 1'b1;
            count[DET_TMR] = '0;
            armed[BTN_TMR] = 1'b0;
            count[BTN_TMR] = '0;
            prev_det       = 1'b1;
            prev_btn       = 1'b1;
            pending_words.delete();
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_W-1:0] value);
            debounce[idx] = value;
        endfunction

        // Advance one timer by a tick; return 1 when it runs out
        function logic expire(int k);
            if (!armed[k]) return 1'b0;
            if (count[k] == '0) begin
                armed[k] = 1'b0;
                return 1'b1;
            end
            count[k] = count[k] - 1'b1;
            return 1'b0;
        endfunction

        // Predict the result word of one accepted tick and queue it
        function void note_tick(logic det, logic btn);
            t_result  word;
            t_jack_ev jev;
            t_btn_ev  bev;
            logic     det_fired;
            logic     btn_fired;
            jev = JEV_NONE;
            bev = BEV_NONE;

            // restart the button timer on a button edge, only with a mic headset in
            if (btn != prev_btn && mic_in) begin
                count[BTN_TMR] = btn ? debounce[CFG_RELEASE] : debounce[CFG_PRESS];
                armed[BTN_TMR] = 1'b1;
            end

            // restart the detect timer on a detect edge; cancel the button timer if occupied
            if (det != prev_det) begin
                if (jack == JACK_EMPTY) begin
                    count[DET_TMR] = debounce[CFG_PLUG];
                end else begin
                    armed[BTN_TMR] = 1'b0;
                    count[BTN_TMR] = '0;
                    count[DET_TMR] = debounce[CFG_UNPLUG];
                end
                armed[DET_TMR] = 1'b1;
            end
            prev_det = det;
            prev_btn = btn;

            // classify an insertion or confirm a removal
            det_fired = expire(DET_TMR);
            if (det_fired) begin
                if (det) begin
                    if (jack != JACK_EMPTY) begin
                        jack   = JACK_EMPTY;
                        mic_in = 1'b0;
                        jev    = JEV_REMOVED;
                        if (held) begin
                            held = 1'b0;
                            bev  = BEV_RELEASE;
                        end
                    end
                end else if (jack == JACK_EMPTY) begin
                    if (btn) begin
                        jack   = JACK_MIC;
                        mic_in = 1'b1;
                        jev    = JEV_MIC;
                    end else begin
                        jack = JACK_PHONES;
                        jev  = JEV_PHONES;
                    end
                end
            end

            // report a press or release only when it changes the held state
            btn_fired = expire(BTN_TMR);
            if (btn_fired && jack == JACK_MIC && !det) begin
                if (!btn && !held) begin
                    held = 1'b1;
                    bev  = BEV_PRESS;
                end else if (btn && held) begin
                    held = 1'b0;
                    bev  = BEV_RELEASE;
                end
            end

            word.jack_state   = jack;
            word.button_down  = held;
            word.jack_event   = jev;
            word.button_event = bev;
            pending_words.push_back(word);
        endfunction

        // Compare one result word with the oldest prediction
        function void check_word(t_result got);
            t_result want;
            if (pending_words.size() == 0) begin
                faults++;
                if (reported < 10) begin
                    reported++;
                    $display("[%0t] unexpected result word: jack %0d btn %0d jev %0d bev %0d",
                             $time, got.jack_state, got.button_down, got.jack_event,
                             got.button_event);
                end
                return;
            end
            want = pending_words.pop_front();
            if (got.jack_state !== want.jack_state || got.button_down !== want.button_down ||
                got.jack_event !== want.jack_event || got.button_event !== want.button_event) begin
                faults++;
                if (reported < 10) begin
                    reported++;
                    $display("[%0t] exp/act: jack %0d/%0d btn %0d/%0d jev %0d/%0d bev %0d/%0d",
                             $time, want.jack_state, got.jack_state, want.button_down,
                             got.button_down, want.jack_event, got.jack_event,
                             want.button_event, got.button_event);
                end
            end
        endfunction

    endclass

endpackage

[tb/tb_headset_jack_detect_debounce_top.sv]
// Testbench top for the headset jack detect and button debounce block.
`timescale 1ns / 100ps

module tb_headset_jack_detect_debounce_top;

    import hjdd_pkg::*;
    import hjdd_tb_pkg::*;

    localparam int STALL_LIMIT = 1000;

    logic             clk   = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we;
    t_cfg_idx         cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    logic calm     = 1'b0;
    logic last_det = 1'b1;
    logic last_btn = 1'b1;
    int   quiet    = 0;

    jack_scoreboard sb;

    hjdd_in_if  in_if ();
    hjdd_out_if out_if ();

    headset_jack_detect_debounce_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Send one tick word, with a random gap ahead of it
    task automatic send_tick(input logic det, input logic btn);
        if (!calm && $urandom_range(0, 11) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_if.valid        <= 1'b1;
        in_if.detect_level <= det;
        in_if.button_level <= btn;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        sb.note_tick(det, btn);
        last_det = det;
        last_btn = btn;
    endtask

    // Hold the sender until every predicted word has come back
    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (sb.pending_words.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Write all four debounce lengths while the block is idle
    task automatic apply_debounce(input logic [CFG_W-1:0] plug, input logic [CFG_W-1:0] unplug,
                                  input logic [CFG_W-1:0] press, input logic [CFG_W-1:0] rel);
        logic [CFG_W-1:0] vals [4];
        vals[0] = plug;
        vals[1] = unplug;
        vals[2] = press;
        vals[3] = rel;
        drain_results();
        for (int i = 0; i < 4; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= t_cfg_idx'(i);
            cfg_data <= vals[i];
            sb.set_reg(t_cfg_idx'(i), vals[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Drive runs of steady pin levels with contact bounce at run starts and some noisy runs
    task automatic run_ticks(input int n_items, input int det_lo, input int det_hi,
                             input int btn_hi);
        int   det_left;
        int   btn_left;
        int   det_age;
        int   btn_age;
        logic det_lvl;
        logic btn_lvl;
        logic det_now;
        logic btn_now;
        logic det_noisy;
        logic btn_noisy;
        det_left  = 0;
        btn_left  = 0;
        det_age   = 0;
        btn_age   = 0;
        det_lvl   = last_det;
        btn_lvl   = last_btn;
        det_noisy = 1'b0;
        btn_noisy = 1'b0;
        repeat (n_items) begin
            if (det_left == 0) begin
                if ($urandom_range(0, 3) != 0) det_lvl = ~det_lvl;
                det_left  = $urandom_range(det_lo, det_hi);
                det_noisy = ($urandom_range(0, 5) == 0);
                det_age   = 0;
            end
            if (btn_left == 0) begin
                if ($urandom_range(0, 3) != 0) btn_lvl = ~btn_lvl;
                btn_left  = $urandom_range(1, btn_hi);
                btn_noisy = ($urandom_range(0, 5) == 0);
                btn_age   = 0;
            end
            det_now = det_lvl;
            btn_now = btn_lvl;
            if ((det_age < 2 || det_noisy) && $urandom_range(0, 3) == 0) det_now = ~det_lvl;
            if ((btn_age < 2 || btn_noisy) && $urandom_range(0, 3) == 0) btn_now = ~btn_lvl;
            send_tick(det_now, btn_now);
            det_left--;
            btn_left--;
            det_age++;
            btn_age++;
        end
    endtask

    // Pick small random debounce lengths and run a phase under them
    task automatic shuffle_phase(input int n_items);
        logic [CFG_W-1:0] plug;
        logic [CFG_W-1:0] unplug;
        logic [CFG_W-1:0] press;
        logic [CFG_W-1:0] rel;
        int               det_hi;
        int               btn_hi;
        plug   = 16'($urandom_range(0, 12));
        unplug = 16'($urandom_range(0, 12));
        press  = 16'($urandom_range(0, 12));
        rel    = 16'($urandom_range(0, 12));
        apply_debounce(plug, unplug, press, rel);
        det_hi = 2 * ((plug > unplug) ? plug : unplug) + 4;
        btn_hi = 2 * ((press > rel) ? press : rel) + 4;
        run_ticks(n_items, 1, det_hi, btn_hi);
    endtask

    // Receiver: random stall bursts, steady ready once calm
    initial begin
        out_if.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (!calm && $urandom_range(0, 5) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end else begin
                out_if.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    // Check result words and watch for a stuck block
    always @(posedge clk) begin
        t_result got;
        if (rst_n && out_if.valid && out_if.ready) begin
            got.jack_state   = t_jack'(out_if.jack_state);
            got.button_down  = out_if.button_down;
            got.jack_event   = t_jack_ev'(out_if.jack_event);
            got.button_event = t_btn_ev'(out_if.button_event);
            sb.check_word(got);
        end
        if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet <= 0;
        end else if (quiet >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        in_if.valid        <= 1'b0;
        in_if.detect_level <= 1'b1;
        in_if.button_level <= 1'b1;
        cfg_we             <= 1'b0;
        cfg_idx            <= CFG_PLUG;
        cfg_data           <= '0;
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pending check after reset fires on the empty jack; button edge without mic is ignored
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);

        // Zero debounce: every timer fires on the tick that loads it
        apply_debounce(16'd0, 16'd0, 16'd0, 16'd0);
        send_tick(1'b0, 1'b1);   // mic headset in
        send_tick(1'b0, 1'b0);   // press
        send_tick(1'b0, 1'b1);   // release
        send_tick(1'b0, 1'b0);   // press
        send_tick(1'b1, 1'b0);   // removal releases the held button
        send_tick(1'b0, 1'b0);   // headphones in
        send_tick(1'b0, 1'b1);   // button edge without mic
        send_tick(1'b1, 1'b1);   // removed
        send_tick(1'b0, 1'b1);   // mic headset in
        send_tick(1'b1, 1'b0);   // detect edge cancels the button restart of the same tick
        send_tick(1'b0, 1'b1);

        // Short debounce: timers run out a few ticks after the edge
        apply_debounce(16'd1, 16'd3, 16'd2, 16'd2);
        send_tick(1'b0, 1'b0);   // press timer armed
        send_tick(1'b1, 1'b0);   // detect bounce cancels it
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);   // release edge with nothing held
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);   // press reported
        send_tick(1'b1, 1'b0);   // removal timer starts
        send_tick(1'b1, 1'b1);   // release timer runs out together with the removal
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b1);

        // Random phases over a range of debounce settings
        apply_debounce(16'd0, 16'd0, 16'd0, 16'd0);
        run_ticks(120, 1, 6, 6);
        apply_debounce(16'd3, 16'd2, 16'd4, 16'd1);
        run_ticks(220, 1, 12, 10);
        apply_debounce(PLUG_TICKS_RST, UNPLUG_TICKS_RST, PRESS_TICKS_RST, RELEASE_TICKS_RST);
        run_ticks(380, 120, 320, 90);
        shuffle_phase(180);
        drain_results();
        run_ticks(150, 1, 20, 20);
        apply_debounce(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_ticks(50, 1, 40, 40);
        apply_debounce(16'd0, 16'hFFFF, 16'd0, 16'hFFFF);
        run_ticks(90, 1, 20, 20);

        // Last part without idling on either side
        calm = 1'b1;
        shuffle_phase(120);

        drain_results();
        if (sb.faults == 0 && sb.pending_words.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
